// ===== hdl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types, constants and helpers for the frustum plane / sphere cull block.
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int NUM_PLANES = 6;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_W      = 32 + FRAC_BITS;   // divider numerator / quotient width
   localparam int STEP_W     = $clog2(NUM_W);    // iteration counter
   localparam int PLANE_W    = $clog2(NUM_PLANES);

   typedef logic signed [31:0] word_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   // one queued command: load carries six column sums, query carries center and radius
   typedef struct packed {
      kind_type                    kind;
      logic [1:0]                  row;
      logic [NUM_PLANES-1:0][31:0] word;
   } entry_type;

   // near, far, left, right, top, bottom
   localparam logic [1:0] PLANE_COL [NUM_PLANES] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
   localparam logic       PLANE_ADD [NUM_PLANES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_NSQ_MUL,
      ST_NSQ_ACC,
      ST_SQRT,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_WR,
      ST_QSTART,
      ST_QMUL,
      ST_QACC,
      ST_QCHK
   } state_type;

   typedef struct packed {
      logic pop;
      logic resp;
      logic visible;
      logic pvalid;
   } ctl_type;

   function automatic word_type sat33(input logic signed [32:0] v);
      word_type r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/fpc_front.sv =====
// ----------------------------------------------------------------------------
// fpc_front
// Takes request transfers, forms the six plane column sums of a load row or
// packs the query operands into one queue entry.
// ----------------------------------------------------------------------------
module fpc_front (
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_type,
   input  logic [1:0]              req_row_index,
   input  logic signed [31:0]      req_elem_0,
   input  logic signed [31:0]      req_elem_1,
   input  logic signed [31:0]      req_elem_2,
   input  logic signed [31:0]      req_elem_3,
   input  logic signed [31:0]      req_center_x,
   input  logic signed [31:0]      req_center_y,
   input  logic signed [31:0]      req_center_z,
   input  logic [30:0]             req_radius,
   output logic                    push,
   output fpc_pkg::entry_type      entry
);

   logic signed [31:0] elem [4];
   logic signed [31:0] tcol;
   logic signed [32:0] csum;

   assign push = start & ~busy;

   always_comb begin
      elem[0] = req_elem_0;
      elem[1] = req_elem_1;
      elem[2] = req_elem_2;
      elem[3] = req_elem_3;
      tcol    = '0;
      csum    = '0;
      entry.kind = fpc_pkg::kind_type'(req_type);
      entry.row  = req_row_index;
      entry.word = '0;
      if (req_type == fpc_pkg::KIND_QUERY) begin
         entry.word[0] = req_center_x;
         entry.word[1] = req_center_y;
         entry.word[2] = req_center_z;
         entry.word[3] = {1'b0, req_radius};
      end else begin
         for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
            tcol = elem[fpc_pkg::PLANE_COL[p]];
            if (fpc_pkg::PLANE_ADD[p]) begin
               csum = {elem[3][31], elem[3]} + {tcol[31], tcol};
            end else begin
               csum = {elem[3][31], elem[3]} - {tcol[31], tcol};
            end
            entry.word[p] = fpc_pkg::sat33(csum);
         end
      end
   end

endmodule

// ===== hdl/fpc_queue.sv =====
// ----------------------------------------------------------------------------
// fpc_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module fpc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fpc_pkg::entry_type  push_entry,
   input  logic                pop,
   output fpc_pkg::entry_type  head,
   output logic                head_valid,
   output logic                full
);

   fpc_pkg::entry_type mem_ff [2];
   logic               wr_ff, wr_in;
   logic               rd_ff, rd_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = mem_ff[rd_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/fpc_back.sv =====
// ----------------------------------------------------------------------------
// fpc_back
// Executes queued commands: plane store, normalization (squares, bit-serial
// square root, bit-serial divide) and the per-plane sphere test.
// ----------------------------------------------------------------------------
module fpc_back (
   input  logic                clock,
   input  logic                reset,
   input  fpc_pkg::entry_type  head,
   input  logic                head_valid,
   output logic                pop,
   output logic                rsp_valid,
   output logic                rsp_reply_kind,
   output logic                rsp_inside_res,
   output logic                rsp_planes_valid
);

   localparam int NP = fpc_pkg::NUM_PLANES;
   localparam int NW = fpc_pkg::NUM_W;
   localparam int SW = fpc_pkg::STEP_W;
   localparam int PW = fpc_pkg::PLANE_W;
   localparam int F  = fpc_pkg::FRAC_BITS;

   fpc_pkg::state_type  state_ff, state_in;
   fpc_pkg::ctl_type    ctl;
   fpc_pkg::entry_type  cmd_ff;

   logic signed [31:0]  coeff_ff [NP][4];
   logic [3:0]          rows_ff;
   logic                ready_ff;
   logic [PW-1:0]       plane_ff;
   logic [1:0]          k_ff;
   logic [SW-1:0]       step_ff;
   logic signed [63:0]  prod_ff, prod_in;
   logic [63:0]         sum_ff;
   logic [33:0]         rem_ff;
   logic [31:0]         root_ff;
   logic [31:0]         len_ff;
   logic [NW-1:0]       num_ff;
   logic [NW-1:0]       quo_ff;
   logic [31:0]         drem_ff;
   logic signed [33:0]  acc_ff;
   logic                rsp_valid_ff, rsp_kind_ff, rsp_inside_ff, rsp_pvalid_ff;

   logic signed [31:0]  row [4];
   logic signed [31:0]  mul_a, mul_b;
   logic [3:0]          rows_or;
   logic                load_done, last_plane;
   logic [35:0]         sq_rem_t, sq_trial;
   logic                sq_ge;
   logic [32:0]         dv_t;
   logic                dv_ge;
   logic [31:0]         mag;
   logic signed [63:0]  sh;
   logic signed [31:0]  term;
   logic signed [33:0]  plane_sum;
   logic signed [34:0]  margin;
   logic                culled;
   logic signed [31:0]  norm_val;

   // ---- shared datapath terms ----
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         row[i] = coeff_ff[plane_ff][i];
      end
      rows_or    = rows_ff | (4'b0001 << cmd_ff.row);
      load_done  = (rows_or == 4'hF);
      last_plane = (plane_ff == PW'(NP - 1));
      mul_a      = row[k_ff];
      mul_b      = (state_ff == fpc_pkg::ST_NSQ_MUL) ? row[k_ff]
                                                     : $signed(cmd_ff.word[{1'b0, k_ff}]);
      prod_in    = mul_a * mul_b;

      sq_rem_t   = {rem_ff, sum_ff[63:62]};
      sq_trial   = {2'b00, root_ff, 2'b01};
      sq_ge      = (sq_rem_t >= sq_trial);

      dv_t       = {drem_ff, num_ff[NW-1]};
      dv_ge      = (dv_t >= {1'b0, len_ff});

      mag        = row[k_ff][31] ? 32'(-row[k_ff]) : row[k_ff];

      sh         = prod_ff >>> F;
      if (sh > 64'sh0000_0000_7fff_ffff) begin
         term = 32'sh7fff_ffff;
      end else if (sh < -64'sh0000_0000_8000_0000) begin
         term = 32'sh8000_0000;
      end else begin
         term = sh[31:0];
      end

      plane_sum = acc_ff + {{2{row[3][31]}}, row[3]};
      margin    = {plane_sum[33], plane_sum} + $signed({4'b0000, cmd_ff.word[3][30:0]});
      culled    = margin[34];

      // saturated, sign-restored quotient
      if (row[k_ff][31]) begin
         norm_val = (quo_ff > NW'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-quo_ff[31:0]);
      end else begin
         norm_val = (quo_ff > NW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : quo_ff[31:0];
      end
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpc_pkg::ST_IDLE: begin
            if (head_valid) begin
               state_in = (head.kind == fpc_pkg::KIND_QUERY) ? fpc_pkg::ST_QSTART
                                                               : fpc_pkg::ST_LOAD;
            end
         end
         fpc_pkg::ST_LOAD:
            state_in = load_done ? fpc_pkg::ST_NSQ_MUL : fpc_pkg::ST_IDLE;
         fpc_pkg::ST_NSQ_MUL:
            state_in = fpc_pkg::ST_NSQ_ACC;
         fpc_pkg::ST_NSQ_ACC:
            state_in = (k_ff == 2'd2) ? fpc_pkg::ST_SQRT : fpc_pkg::ST_NSQ_MUL;
         fpc_pkg::ST_SQRT:
            state_in = (step_ff == SW'(31)) ? fpc_pkg::ST_DIV_SETUP : fpc_pkg::ST_SQRT;
         fpc_pkg::ST_DIV_SETUP: begin
            if (len_ff != '0) begin
               state_in = fpc_pkg::ST_DIV;
            end else begin
               state_in = last_plane ? fpc_pkg::ST_IDLE : fpc_pkg::ST_NSQ_MUL;
            end
         end
         fpc_pkg::ST_DIV:
            state_in = (step_ff == SW'(NW - 1)) ? fpc_pkg::ST_DIV_WR : fpc_pkg::ST_DIV;
         fpc_pkg::ST_DIV_WR: begin
            if (k_ff != 2'd3) begin
               state_in = fpc_pkg::ST_DIV_SETUP;
            end else begin
               state_in = last_plane ? fpc_pkg::ST_IDLE : fpc_pkg::ST_NSQ_MUL;
            end
         end
         fpc_pkg::ST_QSTART:
            state_in = ready_ff ? fpc_pkg::ST_QMUL : fpc_pkg::ST_IDLE;
         fpc_pkg::ST_QMUL:
            state_in = fpc_pkg::ST_QACC;
         fpc_pkg::ST_QACC:
            state_in = (k_ff == 2'd2) ? fpc_pkg::ST_QCHK : fpc_pkg::ST_QMUL;
         fpc_pkg::ST_QCHK:
            state_in = (culled || last_plane) ? fpc_pkg::ST_IDLE : fpc_pkg::ST_QMUL;
         default:
            state_in = fpc_pkg::ST_IDLE;
      endcase
   end

   // ---- control outputs ----
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         fpc_pkg::ST_IDLE:
            ctl.pop = head_valid;
         fpc_pkg::ST_LOAD: begin
            ctl.resp   = ~load_done;
            ctl.pvalid = (rows_ff == 4'h0) ? 1'b0 : ready_ff;
         end
         fpc_pkg::ST_DIV_SETUP: begin
            ctl.resp   = (len_ff == '0) & last_plane;
            ctl.pvalid = 1'b1;
         end
         fpc_pkg::ST_DIV_WR: begin
            ctl.resp   = (k_ff == 2'd3) & last_plane;
            ctl.pvalid = 1'b1;
         end
         fpc_pkg::ST_QSTART: begin
            ctl.resp    = ~ready_ff;
            ctl.visible = 1'b1;
            ctl.pvalid  = ready_ff;
         end
         fpc_pkg::ST_QCHK: begin
            ctl.resp    = culled | last_plane;
            ctl.visible = ~culled;
            ctl.pvalid  = ready_ff;
         end
         default: ctl = '0;
      endcase
   end

   assign pop = ctl.pop;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpc_pkg::ST_IDLE;
         rows_ff      <= 4'h0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NP; p++) begin
            for (int i = 0; i < 4; i++) begin
               coeff_ff[p][i] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= ctl.resp;
         if (ctl.pop) begin
            cmd_ff <= head;
         end
         if (ctl.resp) begin
            rsp_kind_ff   <= cmd_ff.kind;
            rsp_inside_ff <= ctl.visible;
            rsp_pvalid_ff <= ctl.pvalid;
         end
         case (state_ff)
            fpc_pkg::ST_LOAD: begin
               for (int p = 0; p < NP; p++) begin
                  coeff_ff[p][cmd_ff.row] <= $signed(cmd_ff.word[p]);
               end
               if (rows_ff == 4'h0) begin
                  ready_ff <= 1'b0;
               end
               rows_ff  <= load_done ? 4'h0 : rows_or;
               plane_ff <= '0;
               k_ff     <= 2'd0;
               sum_ff   <= '0;
            end
            fpc_pkg::ST_NSQ_MUL: begin
               prod_ff <= prod_in;
            end
            fpc_pkg::ST_NSQ_ACC: begin
               sum_ff  <= sum_ff + prod_ff;
               k_ff    <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
               step_ff <= '0;
               rem_ff  <= '0;
               root_ff <= '0;
            end
            fpc_pkg::ST_SQRT: begin
               rem_ff  <= sq_ge ? 34'(sq_rem_t - sq_trial) : sq_rem_t[33:0];
               root_ff <= {root_ff[30:0], sq_ge};
               sum_ff  <= {sum_ff[61:0], 2'b00};
               step_ff <= step_ff + SW'(1);
               if (step_ff == SW'(31)) begin
                  len_ff <= {root_ff[30:0], sq_ge};
               end
            end
            fpc_pkg::ST_DIV_SETUP: begin
               if (len_ff == '0) begin
                  for (int i = 0; i < 4; i++) begin
                     coeff_ff[plane_ff][i] <= '0;
                  end
                  plane_ff <= plane_ff + PW'(1);
                  k_ff     <= 2'd0;
                  sum_ff   <= '0;
                  if (last_plane) begin
                     ready_ff <= 1'b1;
                  end
               end else begin
                  num_ff  <= {mag, {F{1'b0}}} + NW'(len_ff >> 1);
                  quo_ff  <= '0;
                  drem_ff <= '0;
                  step_ff <= '0;
               end
            end
            fpc_pkg::ST_DIV: begin
               drem_ff <= dv_ge ? 32'(dv_t - {1'b0, len_ff}) : dv_t[31:0];
               quo_ff  <= {quo_ff[NW-2:0], dv_ge};
               num_ff  <= {num_ff[NW-2:0], 1'b0};
               step_ff <= step_ff + SW'(1);
            end
            fpc_pkg::ST_DIV_WR: begin
               coeff_ff[plane_ff][k_ff] <= norm_val;
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  plane_ff <= plane_ff + PW'(1);
                  sum_ff   <= '0;
                  if (last_plane) begin
                     ready_ff <= 1'b1;
                  end
               end
            end
            fpc_pkg::ST_QSTART: begin
               plane_ff <= '0;
               k_ff     <= 2'd0;
               acc_ff   <= '0;
            end
            fpc_pkg::ST_QMUL: begin
               prod_ff <= prod_in;
            end
            fpc_pkg::ST_QACC: begin
               acc_ff <= acc_ff + {{2{term[31]}}, term};
               k_ff   <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            end
            fpc_pkg::ST_QCHK: begin
               plane_ff <= plane_ff + PW'(1);
               acc_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = rsp_kind_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_planes_valid = rsp_pvalid_ff;

endmodule

// ===== hdl/frustum_plane_sphere_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull
// View frustum plane extraction from matrix rows and sphere visibility test.
// ----------------------------------------------------------------------------
// Usage: a request transfer happens on a clock where start is high and busy
// is low. Every request gives exactly one response, shown for one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take it then.
// A load (req_type 0) carries one row of the view-projection matrix; a query
// (req_type 1) carries a sphere center and radius, all Q16.16. Requests are
// buffered in a two-entry queue, so busy goes high only when two requests are
// waiting. The back end shares a single 32x32 multiplier and uses one-bit-per-cycle
// root and divide units. Work per request:
//   load that does not complete the matrix: store the row, then respond
//   load that completes the matrix: per plane the sum of squares, the
//     square root and four divides (skipped for a zero-length plane)
//   query: plane by plane, stops at the first culling plane; answered
//     without any plane test when planes are not yet valid
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [1:0]         req_row_index,
   input  logic signed [31:0] req_elem_0,
   input  logic signed [31:0] req_elem_1,
   input  logic signed [31:0] req_elem_2,
   input  logic signed [31:0] req_elem_3,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0]        req_radius,
   output logic               rsp_valid,
   output logic               rsp_reply_kind,
   output logic               rsp_inside_res,
   output logic               rsp_planes_valid
);

   logic               push;
   logic               pop;
   logic               head_valid;
   logic               full;
   fpc_pkg::entry_type push_entry;
   fpc_pkg::entry_type head;

   // queue full stalls the requester
   assign busy = full;

   // front: column sums for loads, operand packing for queries
   fpc_front u_front (
      .start         (start),
      .busy          (full),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .req_elem_0    (req_elem_0),
      .req_elem_1    (req_elem_1),
      .req_elem_2    (req_elem_2),
      .req_elem_3    (req_elem_3),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_center_z  (req_center_z),
      .req_radius    (req_radius),
      .push          (push),
      .entry         (push_entry)
   );

   // decouples request transfers from the long back-end operations
   fpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   // back: plane store, normalization and query evaluation
   fpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_planes_valid (rsp_planes_valid)
   );

endmodule

// ===== hdl/fpc_checker.sv =====
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks on the response stream of the cull block.
// ----------------------------------------------------------------------------
module fpc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_reply_kind,
   input logic rsp_inside_res,
   input logic rsp_planes_valid
);

   // a verdict of inside is only given on queries
   a_inside_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_reply_kind)
      else $error("inside set on a load response");

   // without valid planes nothing is culled
   a_no_cull_unready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind && !rsp_planes_valid |-> rsp_inside_res)
      else $error("query culled before planes valid");

   // back end always passes through idle between responses
   a_resp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

endmodule

bind frustum_plane_sphere_cull fpc_checker u_fpc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_reply_kind   (rsp_reply_kind),
   .rsp_inside_res   (rsp_inside_res),
   .rsp_planes_valid (rsp_planes_valid)
);

// ===== tb/frustum_plane_sphere_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull_test
// Self-checking bench: load/query command stream against a cycle-free model
// of plane extraction, normalization and sphere culling.
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull_test;

   typedef struct {
      fpc_pkg::kind_type  kind;
      logic [1:0]         row;
      logic signed [31:0] e [4];
      logic signed [31:0] cx, cy, cz;
      logic [30:0]        rad;
   } cmd_type;

   typedef struct {
      logic kind;
      logic visible;
      logic pvalid;
   } verdict_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_type = 1'b0;
   logic [1:0]         req_row_index = '0;
   logic signed [31:0] req_elem_0 = '0, req_elem_1 = '0, req_elem_2 = '0, req_elem_3 = '0;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [30:0]        req_radius = '0;
   logic               rsp_valid, rsp_reply_kind, rsp_inside_res, rsp_planes_valid;

   frustum_plane_sphere_cull uut (.*);

   always #2 clock = ~clock;

   // model state
   logic signed [31:0] coeff [fpc_pkg::NUM_PLANES*4];
   logic [3:0]         row_mask;
   logic               ready;

   cmd_type     pending [$];
   verdict_type verdicts [$];
   int          mismatches = 0;
   longint      cycles = 0;
   bit          stim_done = 0;
   bit          hold = 0;        // pause the sender until responses drain

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // floor shift of an exact 64-bit product
   function automatic longint fshift(longint p);
      return p >>> fpc_pkg::FRAC_BITS;
   endfunction

   function automatic void rescale_planes();
      longint unsigned sq, len, mag, q;
      longint          v;
      for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
         sq = 0;
         for (int k = 0; k < 3; k++) begin
            v = coeff[p*4+k];
            sq += longint'(v * v);
         end
         len = root64(sq);
         for (int k = 0; k < 4; k++) begin
            if (len == 0) begin
               coeff[p*4+k] = '0;
            end else begin
               v = coeff[p*4+k];
               mag = (v < 0) ? -v : v;
               q = ((mag << fpc_pkg::FRAC_BITS) + (len >> 1)) / len;
               coeff[p*4+k] = clamp32((v < 0) ? -longint'(q) : longint'(q));
            end
         end
      end
   endfunction

   function automatic verdict_type cull_step(cmd_type c);
      verdict_type r;
      longint      t, d;
      r.kind = c.kind;
      r.visible = 1'b0;
      if (c.kind == fpc_pkg::KIND_LOAD) begin
         if (row_mask == 0) ready = 1'b0;
         for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
            t = c.e[fpc_pkg::PLANE_COL[p]];
            coeff[p*4+c.row] = clamp32(fpc_pkg::PLANE_ADD[p] ? longint'(c.e[3]) + t
                                                             : longint'(c.e[3]) - t);
         end
         row_mask |= 4'b1 << c.row;
         if (row_mask == 4'hf) begin
            rescale_planes();
            ready = 1'b1;
            row_mask = '0;
         end
      end else begin
         r.visible = 1'b1;
         if (ready) begin
            for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
               d = longint'(clamp32(fshift(longint'(coeff[p*4+0]) * c.cx)))
                 + longint'(clamp32(fshift(longint'(coeff[p*4+1]) * c.cy)))
                 + longint'(clamp32(fshift(longint'(coeff[p*4+2]) * c.cz)))
                 + longint'(coeff[p*4+3]);
               if (d < -longint'(c.rad)) begin
                  r.visible = 1'b0;
                  break;
               end
            end
         end
      end
      r.pvalid = ready;
      return r;
   endfunction

   // random 32-bit value, skewed toward edges and small Q16.16 numbers
   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'($urandom);
         3: return 32'($urandom_range(0, 3));
         default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic cmd_type mk_load(logic [1:0] row);
      cmd_type c;
      c.kind = fpc_pkg::KIND_LOAD;
      c.row  = row;
      foreach (c.e[k]) c.e[k] = rnd_word();
      c.cx = 32'($urandom); c.cy = 32'($urandom); c.cz = 32'($urandom);
      c.rad = 31'($urandom);
      return c;
   endfunction

   function automatic cmd_type mk_query();
      cmd_type c;
      c = mk_load(2'($urandom));
      c.kind = fpc_pkg::KIND_QUERY;
      c.cx = rnd_word(); c.cy = rnd_word(); c.cz = rnd_word();
      case ($urandom_range(0, 3))
         0: c.rad = '0;
         1: c.rad = 31'h7fff_ffff;
         default: c.rad = 31'($urandom_range(0, 32'h0010_0000));
      endcase
      return c;
   endfunction

   // plausible perspective-like matrix: diagonal-heavy rows
   task automatic push_matrix(bit shuffled);
      cmd_type c;
      int      order [4] = '{0, 1, 2, 3};
      if (shuffled) order.shuffle();
      foreach (order[i]) begin
         c = mk_load(2'(order[i]));
         if ($urandom_range(0, 3) != 0) begin
            foreach (c.e[k])
               c.e[k] = (k == order[i]) ? 32'sh0001_0000 + 32'($urandom_range(0, 32'h3_0000))
                                        : $signed(32'($urandom_range(0, 32'h2000))) - 32'sh1000;
            if (order[i] == 2) c.e[3] = 32'sh0001_0000;
            if (order[i] == 3) c.e[2] = -32'sh0001_0000;
         end
         pending.push_back(c);
      end
   endtask

   // stimulus
   initial begin
      cmd_type c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: query before planes exist, extremes, zero matrix, repeated row
      pending.push_back(mk_query());
      for (int r = 0; r < 4; r++) begin
         c = mk_load(2'(r));
         foreach (c.e[k]) c.e[k] = (r[0] ^ k[0]) ? 32'sh7fff_ffff : 32'sh8000_0000;
         pending.push_back(c);
      end
      c = mk_query(); c.cx = 32'sh7fff_ffff; c.cy = 32'sh8000_0000; c.cz = '0; c.rad = '0;
      pending.push_back(c);
      c = mk_query(); c.rad = 31'h7fff_ffff; pending.push_back(c);
      for (int r = 0; r < 4; r++) begin     // all-zero matrix: zero-length planes
         c = mk_load(2'(r));
         foreach (c.e[k]) c.e[k] = '0;
         pending.push_back(c);
      end
      pending.push_back(mk_query());
      c = mk_load(2'd1); pending.push_back(c);
      c = mk_load(2'd1); pending.push_back(c);  // overwrite before completion
      c = mk_load(2'd0); pending.push_back(c);
      c = mk_load(2'd3); pending.push_back(c);
      c = mk_query(); pending.push_back(c);     // stale planes are invalid now
      c = mk_load(2'd2); pending.push_back(c);
      for (int i = 0; i < 3; i++) pending.push_back(mk_query());

      // random: mostly whole matrices followed by query bursts, some stray loads
      while (pending.size() > 0) @(posedge clock);
      for (int n = 0; n < 400; ) begin
         if ($urandom_range(0, 9) < 7) begin
            push_matrix($urandom_range(0, 1));
            n += 4;
         end else begin
            pending.push_back(mk_load(2'($urandom)));
            n++;
         end
         for (int q = $urandom_range(0, 12); q > 0; q--) begin
            pending.push_back(mk_query());
            n++;
         end
         if (n > 200 && n < 220) begin
            while (pending.size() > 0) @(posedge clock);
            hold = 1'b1;
            while (verdicts.size() > 0) @(posedge clock);
            hold = 1'b0;
         end
         while (pending.size() > 8) @(posedge clock);
      end
      while (pending.size() > 0) @(posedge clock);
      stim_done = 1'b1;
   end

   // driver: bursts with random gaps
   int burst = 0, gap = 0;
   always @(posedge clock) begin
      cmd_type     c;
      verdict_type v;
      if (reset) begin
         start <= 1'b0;
         for (int i = 0; i < fpc_pkg::NUM_PLANES*4; i++) coeff[i] = '0;
         row_mask = '0;
         ready = 1'b0;
      end else begin
         if (start && !busy) begin
            // transfer of the current item happened at this edge
            c = pending.pop_front();
            v = cull_step(c);
            verdicts.push_back(v);
         end
         if (start && busy) begin
            // keep holding the same item
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (pending.size() > 0 && !hold) begin
            c = pending[0];
            start <= 1'b1;
            req_type <= c.kind;
            req_row_index <= c.row;
            req_elem_0 <= c.e[0]; req_elem_1 <= c.e[1];
            req_elem_2 <= c.e[2]; req_elem_3 <= c.e[3];
            req_center_x <= c.cx; req_center_y <= c.cy; req_center_z <= c.cz;
            req_radius <= c.rad;
            if (burst > 0) begin
               burst--;
            end else begin
               burst = $urandom_range(0, 20);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is compared with the oldest expectation
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response kind=%0b", rsp_reply_kind);
         end else begin
            v = verdicts.pop_front();
            if (rsp_reply_kind !== v.kind || rsp_inside_res !== v.visible ||
                rsp_planes_valid !== v.pvalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch kind/inside/pvalid exp %0b%0b%0b got %0b%0b%0b",
                           v.kind, v.visible, v.pvalid,
                           rsp_reply_kind, rsp_inside_res, rsp_planes_valid);
            end
         end
      end
   end

   // end of run and watchdog
   int tail = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > 3_000_000) begin
         $display("Verification failed");
         $finish;
      end else if (stim_done && !start && verdicts.size() == 0) begin
         tail++;
         if (tail > 100) begin
            if (mismatches == 0) begin
               $display("Verification passed");
            end else begin
               $display("Verification failed");
            end
            $finish;
         end
      end
   end

endmodule
